### rtl/bba_pkg.sv
// Types and codes shared by the bitmap block allocator modules.
// Depends on nothing.
`default_nettype none
package bba_pkg;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] STAT_ALLOC   = 2'd0;
  localparam logic [1:0] STAT_FAIL    = 2'd1;
  localparam logic [1:0] STAT_FREED   = 2'd2;
  localparam logic [1:0] STAT_IGNORED = 2'd3;

  typedef struct packed {
    logic        func;
    logic [9:0]  words;
    logic [11:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot;
    logic [4:0]  block;
    logic [11:0] base_address;
    logic        slot_released;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_OPEN,
    ST_FDEC,
    ST_FREE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic scan;
    logic open;
    logic fdec;
    logic free;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic early_fail;
    logic fit;
    logic last_k;
    logic free_bad;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

### rtl/bba_ctrl.sv
// Sequencer for the bitmap block allocator.
// Depends on bba_pkg; drives commands to bba_dpath.
`default_nettype none
module bba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output bba_pkg::cmd_t      cmd,
  input  wire bba_pkg::sts_t sts,
  output logic               in_stall
);
  import bba_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_PREP;
      ST_PREP: begin
        if (sts.func == FUNC_FREE) state_nxt = ST_FDEC;
        else if (sts.early_fail)   state_nxt = ST_DONE;
        else                       state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.fit)         state_nxt = ST_DONE;
        else if (sts.last_k) state_nxt = ST_OPEN;
      end
      ST_OPEN: state_nxt = ST_DONE;
      ST_FDEC: state_nxt = sts.free_bad ? ST_DONE : ST_FREE;
      ST_FREE: state_nxt = ST_DONE;
      ST_DONE: if (!sts.out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_PREP: cmd.prep = 1'b1;
      ST_SCAN: cmd.scan = 1'b1;
      ST_OPEN: cmd.open = 1'b1;
      ST_FDEC: cmd.fdec = 1'b1;
      ST_FREE: cmd.free = 1'b1;
      ST_DONE: cmd.emit = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/bba_dpath.sv
// Slot maps, first-fit search, address decode and result register.
// Depends on bba_pkg; commanded by bba_ctrl.
`default_nettype none
module bba_dpath #(
  parameter int SLOTS       = 8,
  parameter int CHUNK_WORDS = 507
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bba_pkg::in_item_t in_data,
  input  wire bba_pkg::cmd_t     cmd,
  output bba_pkg::sts_t          sts,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output bba_pkg::out_item_t     out_data
);
  import bba_pkg::*;

  localparam int BW  = CHUNK_WORDS >> 5;
  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW1 = SW + 1;

  logic [SLOTS-1:0] active_r;
  logic [31:0]      used_r [SLOTS];
  logic [31:0]      cont_r [SLOTS];
  logic [SW-1:0]    last_slot_r;

  in_item_t      in_r;
  logic [5:0]    nb_r;
  logic [31:0]   runmask_r;
  logic [SW-1:0] start_r;
  logic [SW-1:0] k_r;
  logic [11:0]   rem_r;
  logic          free_ok_r;

  logic [1:0]    stat_r;
  logic [SW-1:0] slot_r;
  logic [4:0]    blk_r;
  logic          rel_r;

  logic          out_valid_r;
  out_item_t     out_r;

  // block count and early failure
  logic [5:0]  nb_c;
  logic        early_fail_c;
  always_comb begin
    nb_c = 6'd0;
    for (int n = 0; n < 32; n++) begin
      if (13'(in_r.words) > 13'(n * BW)) nb_c = 6'(n + 1);
    end
    early_fail_c = (in_r.words == 10'd0) || (13'(in_r.words) > 13'(32 * BW));
  end

  // current slot of the round-robin scan
  logic [SW1-1:0] sum_c;
  logic [SW-1:0]  cur_s;
  always_comb begin
    sum_c = SW1'(start_r) + SW1'(k_r);
    if (sum_c >= SW1'(SLOTS)) sum_c = sum_c - SW1'(SLOTS);
    cur_s = sum_c[SW-1:0];
  end

  // parallel first fit in the current slot
  logic        fit_any;
  logic [4:0]  fit_pos;
  logic [31:0] fit_mask;
  always_comb begin
    fit_any  = 1'b0;
    fit_pos  = 5'd0;
    for (int f = 31; f >= 0; f--) begin
      if ((6'(f) <= (6'd32 - nb_r)) && ((used_r[cur_s] & (runmask_r << f)) == 32'd0)) begin
        fit_any = 1'b1;
        fit_pos = 5'(f);
      end
    end
    fit_mask = runmask_r << fit_pos;
  end

  // lowest inactive slot
  logic          inact_any;
  logic [SW-1:0] inact_s;
  always_comb begin
    inact_any = 1'b0;
    inact_s   = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!active_r[s]) begin
        inact_any = 1'b1;
        inact_s   = SW'(s);
      end
    end
  end

  // slot decode of a free address
  logic [SW1-1:0] sdec_c;
  logic [16:0]    sbase_c;
  logic           sdec_ok;
  always_comb begin
    sdec_c  = '0;
    sbase_c = 17'd0;
    for (int k = 1; k <= SLOTS; k++) begin
      if (17'(in_r.address) >= 17'(k * CHUNK_WORDS)) begin
        sdec_c  = SW1'(k);
        sbase_c = 17'(k * CHUNK_WORDS);
      end
    end
    sdec_ok = (sdec_c < SW1'(SLOTS)) && active_r[sdec_c[SW-1:0]];
  end

  // block decode of the remainder
  logic [4:0] bdec_c;
  logic       free_bad_c;
  always_comb begin
    bdec_c = 5'd0;
    for (int n = 1; n < 32; n++) begin
      if (rem_r >= 12'(n * BW)) bdec_c = 5'(n);
    end
    free_bad_c = !free_ok_r || (13'(rem_r) >= 13'(32 * BW));
  end

  // clear mask: the freed block plus the continuation run above it
  logic [32:0] above_c;
  logic [32:0] run_c;
  logic [31:0] cont_clr;
  logic [31:0] used_new;
  always_comb begin
    above_c  = {1'b0, cont_r[slot_r]} >> (6'(blk_r) + 6'd1);
    run_c    = (~above_c & (above_c + 33'd1)) - 33'd1;
    cont_clr = 32'(run_c << (6'(blk_r) + 6'd1));
    used_new = used_r[slot_r] & ~(cont_clr | (32'd1 << blk_r));
  end

  logic [16:0] base_full;
  assign base_full = 17'(slot_r) * 17'(CHUNK_WORDS) + 17'(blk_r) * 17'(BW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      last_slot_r <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        used_r[s] <= '1;
        cont_r[s] <= '0;
      end
    end else begin
      if (cmd.scan && fit_any && active_r[cur_s]) begin
        used_r[cur_s] <= used_r[cur_s] | fit_mask;
        cont_r[cur_s] <= (cont_r[cur_s] | fit_mask) & ~(32'd1 << fit_pos);
        last_slot_r   <= cur_s;
      end
      if (cmd.open && inact_any) begin
        active_r[inact_s] <= 1'b1;
        used_r[inact_s]   <= runmask_r;
        cont_r[inact_s]   <= runmask_r & ~32'd1;
        last_slot_r       <= inact_s;
      end
      if (cmd.free) begin
        cont_r[slot_r] <= cont_r[slot_r] & ~cont_clr;
        if (used_new == 32'd0) begin
          active_r[slot_r] <= 1'b0;
          used_r[slot_r]   <= '1;
          if (last_slot_r == slot_r) last_slot_r <= '0;
        end else begin
          used_r[slot_r] <= used_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_data;
    if (cmd.prep) begin
      nb_r      <= nb_c;
      runmask_r <= 32'((33'd1 << nb_c) - 33'd1);
      start_r   <= (SW1'(last_slot_r) < SW1'(SLOTS)) ? last_slot_r : '0;
      k_r       <= '0;
      rem_r     <= 12'(17'(in_r.address) - sbase_c);
      free_ok_r <= sdec_ok;
      slot_r    <= (in_r.func == FUNC_ALLOC) ? '0 : sdec_c[SW-1:0];
      stat_r    <= STAT_FAIL;
      blk_r     <= 5'd0;
      rel_r     <= 1'b0;
    end
    if (cmd.scan) begin
      k_r <= k_r + SW'(1);
      if (fit_any && active_r[cur_s]) begin
        stat_r <= STAT_ALLOC;
        slot_r <= cur_s;
        blk_r  <= fit_pos;
      end
    end
    if (cmd.open && inact_any) begin
      stat_r <= STAT_ALLOC;
      slot_r <= inact_s;
      blk_r  <= 5'd0;
    end
    if (cmd.fdec) begin
      if (free_bad_c) begin
        stat_r <= STAT_IGNORED;
        slot_r <= '0;
        blk_r  <= 5'd0;
      end else begin
        blk_r <= bdec_c;
      end
    end
    if (cmd.free) begin
      stat_r <= STAT_FREED;
      rel_r  <= (used_new == 32'd0);
    end
    if (cmd.emit) begin
      out_r.status        <= stat_r;
      out_r.slot          <= 3'(slot_r);
      out_r.block         <= blk_r;
      out_r.base_address  <= base_full[11:0];
      out_r.slot_released <= rel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts.func       = in_r.func;
    sts.early_fail = early_fail_c;
    sts.fit        = fit_any && active_r[cur_s];
    sts.last_k     = (k_r == SW'(SLOTS - 1));
    sts.free_bad   = free_bad_c;
    sts.out_busy   = out_valid_r && out_stall;
  end

endmodule
`default_nettype wire

### rtl/bitmap_block_allocator_core.sv
// Top level of the bitmap first-fit block allocator.
// Depends on bba_pkg, bba_ctrl and bba_dpath.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_data  (func, words, address)
//   out_    | output    | out_valid/out_stall| out_data (status, slot, block,
//           |           |                    |   base_address, slot_released)
//
// Allocate loads and prepares the item, then scans one slot per cycle (up to SLOTS),
// then opens the lowest inactive slot if no active slot fits.
// Free decodes the slot, then the block, then clears; an ignored free skips the clear.
// Reset sets every slot inactive and clears last slot.
// One item is worked at a time; a result waits in the output register while
// the next item is accepted, and a stalled result holds the sequencer at done.
`default_nettype none
module bitmap_block_allocator_core #(
  parameter int SLOTS       = 8,
  parameter int CHUNK_WORDS = 507
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bba_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bba_pkg::out_item_t      out_data
);
  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .cmd      (cmd),
    .sts      (sts),
    .in_stall (in_stall)
  );

  bba_dpath #(
    .SLOTS       (SLOTS),
    .CHUNK_WORDS (CHUNK_WORDS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("accepted a second item while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == STAT_FAIL || out_data.status == STAT_IGNORED))
      |-> (out_data.slot == 3'd0 && out_data.block == 5'd0 &&
           out_data.base_address == 12'd0 && !out_data.slot_released))
    else $error("failed result carries nonzero fields");

  a_alloc_no_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STAT_ALLOC) |-> !out_data.slot_released)
    else $error("allocation reported a slot release");

endmodule
`default_nettype wire

### sim/tb_bitmap_block_allocator_core.sv
// Testbench for bitmap_block_allocator_core: random and directed allocate/free items,
// results checked against an in-bench model of the slot bitmaps.
// Depends on bba_pkg and the allocator RTL.
`default_nettype none
module tb_bitmap_block_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int NSLOT = 8;
  localparam int CHUNK = 507;
  localparam int BLKW  = CHUNK >> 5;
  localparam int NUM_RANDOM = 430;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  bitmap_block_allocator_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // allocator model state
  logic        mdl_active [NSLOT];
  logic [31:0] mdl_used   [NSLOT];
  logic [31:0] mdl_cont   [NSLOT];
  int          mdl_last;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  // addresses of runs handed out, used to build sensible frees
  logic [11:0] live_addrs[$];

  int  n_mismatch = 0;
  bit  quiet_mode = 1'b0;
  bit  hold_request = 1'b0;
  longint cycle_count = 0;

  function automatic out_item_t mk_res(logic [1:0] st, int s, int b, bit rel);
    out_item_t r;
    r.status = st;
    r.slot = s[2:0];
    r.block = b[4:0];
    r.base_address = (st == STAT_ALLOC || st == STAT_FREED) ? 12'(s * CHUNK + b * BLKW) : '0;
    r.slot_released = rel;
    return r;
  endfunction

  function automatic out_item_t predict_alloc_free(in_item_t it);
    int nblk, s, f, blk, a;
    logic [31:0] runmask, m;
    if (it.func == FUNC_ALLOC) begin
      if (it.words == 0) return mk_res(STAT_FAIL, 0, 0, 0);
      nblk = (int'(it.words) + BLKW - 1) / BLKW;
      if (nblk > 32) return mk_res(STAT_FAIL, 0, 0, 0);
      runmask = (nblk == 32) ? 32'hFFFF_FFFF : ((32'd1 << nblk) - 1);
      for (int k = 0; k < NSLOT; k++) begin
        s = ((mdl_last < NSLOT ? mdl_last : 0) + k) % NSLOT;
        if (mdl_active[s]) begin
          for (f = 0; f < 33 - nblk; f++) begin
            m = runmask << f;
            if ((mdl_used[s] & m) == 0) begin
              mdl_used[s] |= m;
              mdl_cont[s] = (mdl_cont[s] | m) & ~(32'd1 << f);
              mdl_last = s;
              return mk_res(STAT_ALLOC, s, f, 0);
            end
          end
        end
      end
      for (s = 0; s < NSLOT; s++) begin
        if (!mdl_active[s]) begin
          mdl_active[s] = 1'b1;
          mdl_used[s] = runmask;
          mdl_cont[s] = runmask & ~32'd1;
          mdl_last = s;
          return mk_res(STAT_ALLOC, s, 0, 0);
        end
      end
      return mk_res(STAT_FAIL, 0, 0, 0);
    end
    a = it.address;
    s = a / CHUNK;
    if (s >= NSLOT || !mdl_active[s]) return mk_res(STAT_IGNORED, 0, 0, 0);
    blk = (a - s * CHUNK) / BLKW;
    if (blk >= 32) return mk_res(STAT_IGNORED, 0, 0, 0);
    mdl_used[s][blk] = 1'b0;
    for (int b = blk + 1; b < 32; b++) begin
      if (!mdl_cont[s][b]) break;
      mdl_used[s][b] = 1'b0;
      mdl_cont[s][b] = 1'b0;
    end
    if (mdl_used[s] == 0) begin
      mdl_active[s] = 1'b0;
      mdl_used[s] = '1;
      if (mdl_last == s) mdl_last = 0;
      return mk_res(STAT_FREED, s, blk, 1);
    end
    return mk_res(STAT_FREED, s, blk, 0);
  endfunction

  function automatic in_item_t mk_item(logic fn, int w, int a);
    in_item_t it;
    it.func = fn;
    it.words = w[9:0];
    it.address = a[11:0];
    return it;
  endfunction

  // driver: hold the item until accepted, idle now and then
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_alloc_free(in_data));
        if (in_data.func == FUNC_ALLOC)
          live_addrs.push_back(12'(expected_results[$].base_address));
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && (quiet_mode || $urandom_range(99) >= 10)) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold when asked
  always @(posedge clk) begin
    if (rst_n)
      out_stall <= hold_request || (!quiet_mode && $urandom_range(99) < 10);
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = expected_results.pop_front();
        if (e.status !== out_data.status || e.slot !== out_data.slot ||
            e.block !== out_data.block || e.base_address !== out_data.base_address ||
            e.slot_released !== out_data.slot_released) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("mismatch: expected %p, got %p", e, out_data);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bitmap_block_allocator_core test failed");
      $finish;
    end
  end

  // long receiver hold-off while the sender keeps offering items
  initial begin
    int held;
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_request = 1'b1;
    held = 0;
    while (held < 200) begin
      @(posedge clk);
      held++;
    end
    hold_request = 1'b0;
  end

  initial begin
    int r, w, a, sel;
    for (int s = 0; s < NSLOT; s++) begin
      mdl_active[s] = 1'b0;
      mdl_used[s] = '1;
      mdl_cont[s] = '0;
    end
    mdl_last = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: failures, extremes, ignored frees, partial frees, release
    pending_items.push_back(mk_item(FUNC_ALLOC, 0, 0));
    pending_items.push_back(mk_item(FUNC_ALLOC, 1023, 4095));
    pending_items.push_back(mk_item(FUNC_ALLOC, 32 * BLKW + 1, 0));
    pending_items.push_back(mk_item(FUNC_FREE, 0, 0));
    pending_items.push_back(mk_item(FUNC_FREE, 1023, 4095));
    pending_items.push_back(mk_item(FUNC_ALLOC, 1, 0));
    pending_items.push_back(mk_item(FUNC_ALLOC, 32 * BLKW, 0));
    pending_items.push_back(mk_item(FUNC_ALLOC, BLKW + 1, 0));
    pending_items.push_back(mk_item(FUNC_FREE, 0, 32 * BLKW));
    pending_items.push_back(mk_item(FUNC_FREE, 0, BLKW + 1));
    pending_items.push_back(mk_item(FUNC_FREE, 0, 2 * BLKW));
    pending_items.push_back(mk_item(FUNC_FREE, 0, 0));
    pending_items.push_back(mk_item(FUNC_FREE, 0, CHUNK));
    pending_items.push_back(mk_item(FUNC_FREE, 0, CHUNK));
    for (int i = 0; i < 9; i++)
      pending_items.push_back(mk_item(FUNC_ALLOC, 32 * BLKW, 0));
    pending_items.push_back(mk_item(FUNC_FREE, 0, 7 * CHUNK + 5));

    // random: mostly real allocate/free traffic, some noise
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 150) quiet_mode = 1'b1;
      if (i == 220) quiet_mode = 1'b0;
      while (pending_items.size() > 8) @(posedge clk);
      sel = $urandom_range(99);
      if (sel < 45) begin
        r = $urandom_range(99);
        w = (r < 70) ? $urandom_range(1, 6 * BLKW) :
            (r < 95) ? $urandom_range(1, 32 * BLKW) : $urandom_range(1023);
        pending_items.push_back(mk_item(FUNC_ALLOC, w, $urandom_range(4095)));
      end else if (sel < 85 && live_addrs.size() > 0) begin
        r = $urandom_range(live_addrs.size() - 1);
        a = live_addrs[r];
        live_addrs.delete(r);
        pending_items.push_back(mk_item(FUNC_FREE, $urandom_range(1023), a));
      end else begin
        pending_items.push_back(mk_item(FUNC_FREE, $urandom_range(1023),
                                        $urandom_range(4095)));
      end
    end

    wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (n_mismatch == 0 && expected_results.size() == 0)
      $display("bitmap_block_allocator_core test passed");
    else
      $display("bitmap_block_allocator_core test failed");
    $finish;
  end
endmodule
`default_nettype wire
